FILE: rtl/key_value_table_core_defines.svh
// Assertion macros for the key/value table RTL.
// Needs clk and rst_n in the scope of every use.
`ifndef KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define KEY_VALUE_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define KVT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define KVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/kvt_pkg.sv
// Operation codes and types for the key/value table.
// No dependencies.
package kvt_pkg;

    localparam int OP_W = 3;

    typedef logic [OP_W-1:0] op_code_t;

    localparam op_code_t OP_PUT      = 3'd0;
    localparam op_code_t OP_DELETE   = 3'd1;
    localparam op_code_t OP_LOOKUP   = 3'd2;
    localparam op_code_t OP_CONTAINS = 3'd3;
    localparam op_code_t OP_CLEAR    = 3'd4;

endpackage

FILE: rtl/key_value_table_core.sv
// Key/value table: each request scans all slots, one per cycle, through one compare.
// Put, delete, lookup and contains go through the RAM read pipeline and then the
// apply step; clear and unused codes go straight to the apply step. A new item is taken
// only once the last one has been applied; in_ready is high only when idle.
// A waiting result stalls only the apply step. Reset (rst_n, async, active low) empties
// the table; slot contents are not cleared. Needs kvt_pkg, kvt_ram and the defines header.
`include "key_value_table_core_defines.svh"

module key_value_table_core
    import kvt_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [OP_W-1:0]                  operation,
    input  logic [KEY_BITS-1:0]              key,
    input  logic [VALUE_BITS-1:0]            value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found,
    output logic [VALUE_BITS-1:0]            value_out,
    output logic                             full_reject,
    output logic [$clog2(CAPACITY+1)-1:0]    entry_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SLOT_W = KEY_BITS + VALUE_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_APPLY} state_t;

    state_t                  state_reg, state_next;
    op_code_t                op_reg, op_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    rd_active_reg, rd_active_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic [VALUE_BITS-1:0]   hit_val_reg, hit_val_next;
    logic                    free_found_reg, free_found_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;
    logic [CAPACITY-1:0]     slot_valid_reg, slot_valid_next;
    logic [CNT_W-1:0]        count_reg, count_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    found_reg, found_next;
    logic [VALUE_BITS-1:0]   value_out_reg, value_out_next;
    logic                    full_reject_reg, full_reject_next;
    logic [CNT_W-1:0]        entry_count_reg, entry_count_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [SLOT_W-1:0]       ram_wdata;
    logic [SLOT_W-1:0]       ram_rdata;
    logic [KEY_BITS-1:0]     rd_key;
    logic [VALUE_BITS-1:0]   rd_val;
    logic                    scan_op;
    logic                    slot_ok;

    kvt_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (SLOT_W),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rdata)
    );

    assign rd_key  = ram_rdata[SLOT_W-1 -: KEY_BITS];
    assign rd_val  = ram_rdata[VALUE_BITS-1:0];
    assign slot_ok = slot_valid_reg[cmp_idx_reg];

    // Clear and unused codes need no search
    assign scan_op = (operation == OP_PUT) || (operation == OP_DELETE) ||
                     (operation == OP_LOOKUP) || (operation == OP_CONTAINS);

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        rd_idx_next      = rd_idx_reg;
        rd_active_next   = rd_active_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_idx_next     = cmp_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        hit_val_next     = hit_val_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        slot_valid_next  = slot_valid_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg;
        found_next       = found_reg;
        value_out_next   = value_out_reg;
        full_reject_next = full_reject_reg;
        entry_count_next = entry_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = hit_idx_reg;
        ram_wdata        = {key_reg, val_reg};

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = operation;
                    key_next        = key;
                    val_next        = value;
                    rd_idx_next     = '0;
                    rd_active_next  = scan_op;
                    cmp_valid_next  = 1'b0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = scan_op ? ST_SCAN : ST_APPLY;
                end
            end
            ST_SCAN:
            begin
                if (rd_active_reg)
                begin
                    rd_idx_next = IDX_W'(rd_idx_reg + 1'b1);
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        rd_active_next = 1'b0;
                    end
                end
                cmp_valid_next = rd_active_reg;
                cmp_idx_next   = rd_idx_reg;
                // RAM data for cmp_idx_reg is valid this cycle
                if (cmp_valid_reg)
                begin
                    if (slot_ok && (rd_key == key_reg) && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                        hit_val_next = rd_val;
                    end
                    if (!slot_ok && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_APPLY:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    found_next       = 1'b0;
                    value_out_next   = '0;
                    full_reject_next = 1'b0;
                    unique case (op_reg)
                        OP_PUT:
                        begin
                            if (hit_reg)
                            begin
                                ram_we = 1'b1;
                            end
                            else
                            begin
                                found_next = 1'b1;
                                if (free_found_reg)
                                begin
                                    ram_we                         = 1'b1;
                                    ram_waddr                      = free_idx_reg;
                                    slot_valid_next[free_idx_reg]  = 1'b1;
                                    count_next = CNT_W'(count_reg + 1'b1);
                                end
                                else
                                begin
                                    full_reject_next = 1'b1;
                                end
                            end
                        end
                        OP_DELETE:
                        begin
                            if (hit_reg)
                            begin
                                slot_valid_next[hit_idx_reg] = 1'b0;
                                count_next = CNT_W'(count_reg - 1'b1);
                                found_next = 1'b1;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            found_next = hit_reg;
                            if (hit_reg)
                            begin
                                value_out_next = hit_val_reg;
                            end
                        end
                        OP_CONTAINS:
                        begin
                            found_next = hit_reg;
                        end
                        OP_CLEAR:
                        begin
                            slot_valid_next = '0;
                            count_next      = '0;
                        end
                        default:
                        begin
                            // unused code: no change
                        end
                    endcase
                    entry_count_next = count_next;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_PUT;
            key_reg         <= '0;
            val_reg         <= '0;
            rd_idx_reg      <= '0;
            rd_active_reg   <= 1'b0;
            cmp_valid_reg   <= 1'b0;
            cmp_idx_reg     <= '0;
            hit_reg         <= 1'b0;
            hit_idx_reg     <= '0;
            hit_val_reg     <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            slot_valid_reg  <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            value_out_reg   <= '0;
            full_reject_reg <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            key_reg         <= key_next;
            val_reg         <= val_next;
            rd_idx_reg      <= rd_idx_next;
            rd_active_reg   <= rd_active_next;
            cmp_valid_reg   <= cmp_valid_next;
            cmp_idx_reg     <= cmp_idx_next;
            hit_reg         <= hit_next;
            hit_idx_reg     <= hit_idx_next;
            hit_val_reg     <= hit_val_next;
            free_found_reg  <= free_found_next;
            free_idx_reg    <= free_idx_next;
            slot_valid_reg  <= slot_valid_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
            found_reg       <= found_next;
            value_out_reg   <= value_out_next;
            full_reject_reg <= full_reject_next;
            entry_count_reg <= entry_count_next;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign value_out   = value_out_reg;
    assign full_reject = full_reject_reg;
    assign entry_count = entry_count_reg;

    `KVT_ASSERT_NOW(a_count_matches_valid, 1'b1,
        $countones(slot_valid_reg) == count_reg, "count differs from valid slots")
    `KVT_ASSERT_NOW(a_reject_only_when_full, out_valid_reg && full_reject_reg,
        found_reg && (entry_count_reg == FULL_CNT), "reject without full table")
    `KVT_ASSERT_NOW(a_value_only_on_hit, out_valid_reg && (value_out_reg != '0),
        found_reg && !full_reject_reg, "value returned without a hit")
    `KVT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "ready right after accepting an item")

endmodule

FILE: rtl/kvt_ram.sv
// Slot storage: one write port, one read port with registered read data.
// No dependencies.
module kvt_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 48,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
